>>> rtl/npr_pkg.sv
// shared types, constants and sample conversion for the nearest pcm resampler
`default_nettype none

package npr_pkg;

    localparam int FRAC_BITS = 8;
    localparam int IDX_W     = 28;
    localparam int ACC_W     = IDX_W + FRAC_BITS;
    localparam int STEP_W    = 12;
    localparam int TOTAL_W   = 24;
    localparam int SAMPLE_W  = 16;
    localparam int MAX_RES   = 32;
    localparam int CNT_W     = $clog2(MAX_RES + 1);
    localparam int Q_DEPTH   = 2;
    localparam int QPTR_W    = $clog2(Q_DEPTH);
    localparam int QCNT_W    = $clog2(Q_DEPTH + 1);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE  = 2'd0,
        CFG_STEP  = 2'd1,
        CFG_TOTAL = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } t_back_state;

    // queue head as seen by the back end
    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] pcm;
    } t_q_head;

    // back end status for the top level
    typedef struct packed {
        logic               busy;
        logic [TOTAL_W-1:0] done;
    } t_back_stat;

    // 8-bit mode: flip the sign bit of the byte and move it to the top
    function automatic logic [SAMPLE_W-1:0] convert_sample(
        input logic                mode16,
        input logic [SAMPLE_W-1:0] raw
    );
        logic [SAMPLE_W-1:0] res;
        if (mode16) begin
            res = raw;
        end else begin
            res = {~raw[7], raw[6:0], 8'h00};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/npr_front.sv
// front end: accepts source samples, converts them and queues them for the back end
`default_nettype none

module npr_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_mode16,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire [npr_pkg::SAMPLE_W-1:0]  i_raw_sample,
    output npr_pkg::t_q_head             o_head,
    input  wire                          i_pop
);
    import npr_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [Q_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_cnt;
    logic                w_push;
    logic                w_pop;

    assign o_in_stall   = (r_cnt == QCNT_W'(Q_DEPTH));
    assign w_push       = i_in_valid && !o_in_stall;
    assign w_pop        = i_pop && (r_cnt != '0);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.pcm   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= convert_sample(i_mode16, i_raw_sample);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/npr_back.sv
// back end: steps the read position and emits the outputs of each source sample, one per cycle while not stalled
`default_nettype none

module npr_back (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire [npr_pkg::STEP_W-1:0]           i_step,
    input  wire [npr_pkg::TOTAL_W-1:0]          i_total,
    input  npr_pkg::t_q_head                    i_head,
    output logic                                o_pop,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic signed [npr_pkg::SAMPLE_W-1:0] o_pcm_out,
    output logic                                o_is_last,
    output npr_pkg::t_back_stat                 o_stat
);
    import npr_pkg::*;

    t_back_state         r_state, n_state;
    logic [SAMPLE_W-1:0] r_pcm, n_pcm;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [IDX_W-1:0]    r_src, n_src;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [TOTAL_W-1:0]  r_done, n_done;
    logic                r_out_valid, n_out_valid;
    logic [SAMPLE_W-1:0] r_out_pcm, n_out_pcm;
    logic                r_out_last, n_out_last;

    logic [TOTAL_W-1:0]  w_done_inc;
    logic                w_due;
    logic                w_slot_free;

    assign w_done_inc  = r_done + 1'b1;
    assign w_slot_free = !r_out_valid || !i_out_stall;
    // another output is due for the current sample
    assign w_due = (r_cnt != CNT_W'(MAX_RES)) && (r_done < i_total)
                   && (r_acc[ACC_W-1:FRAC_BITS] <= r_src);

    always_comb begin
        n_state     = r_state;
        n_pcm       = r_pcm;
        n_cnt       = r_cnt;
        n_src       = r_src;
        n_acc       = r_acc;
        n_done      = r_done;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_pcm   = r_out_pcm;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_pcm   = i_head.pcm;
                    n_cnt   = '0;
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                if (w_due) begin
                    if (w_slot_free) begin
                        n_out_valid = 1'b1;
                        n_out_pcm   = r_pcm;
                        n_out_last  = (w_done_inc == i_total);
                        n_done      = w_done_inc;
                        n_acc       = r_acc + ACC_W'(i_step);
                        n_cnt       = r_cnt + 1'b1;
                    end
                end else begin
                    // sample finished, move on and take the next one straight away if the queue holds one, else go idle
                    n_src = r_src + 1'b1;
                    if (i_head.valid) begin
                        o_pop = 1'b1;
                        n_pcm = i_head.pcm;
                        n_cnt = '0;
                    end else begin
                        n_state = BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_cnt       <= '0;
            r_src       <= '0;
            r_acc       <= '0;
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_src       <= n_src;
            r_acc       <= n_acc;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pcm      <= n_pcm;
        r_out_pcm  <= n_out_pcm;
        r_out_last <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_pcm_out   = r_out_pcm;
    assign o_is_last   = r_out_last;
    assign o_stat.busy = (r_state == BK_RUN) || r_out_valid;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

>>> rtl/nearest_pcm_resampler_top.sv
// top level of the nearest pcm resampler: registers, front end, queue and back end
`default_nettype none

// channel   direction  handshake                         payload
// in        sink       i_in_valid / o_in_stall           i_raw_sample
// out       source     o_out_valid / i_out_stall         o_pcm_out, o_is_last
// cfg       sink       i_cfg_valid / o_cfg_ready         i_cfg_index, i_cfg_data
//
// in the back end's step loop a source sample gives each of its outputs in turn and then
// takes a closing step that moves the read position on to the next source sample
// the front end converts the sample on acceptance and holds up to two in its queue
// reset is synchronous and active low; all counters and the read position clear
// a stalled output holds its register; the back end waits and the queue fills behind it

module nearest_pcm_resampler_top (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire [npr_pkg::SAMPLE_W-1:0]         i_raw_sample,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic signed [npr_pkg::SAMPLE_W-1:0] o_pcm_out,
    output logic                                o_is_last,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire [npr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire [npr_pkg::CFG_DAT_W-1:0]        i_cfg_data
);
    import npr_pkg::*;

    // configuration registers
    logic               r_mode16;
    logic [STEP_W-1:0]  r_step;
    logic [TOTAL_W-1:0] r_total;

    t_q_head    w_head;
    logic       w_pop;
    t_back_stat w_stat;

    // writes are always taken; the user must write only while the block is idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode16 <= 1'b1;
            r_step   <= STEP_W'(256);
            r_total  <= TOTAL_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MODE:  r_mode16 <= i_cfg_data[0];
                CFG_STEP:  r_step   <= i_cfg_data[STEP_W-1:0];
                CFG_TOTAL: r_total  <= i_cfg_data[TOTAL_W-1:0];
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // front end: accept, convert, queue
    npr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode16     (r_mode16),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_raw_sample (i_raw_sample),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    // back end: position accumulator, output count, output register
    npr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (r_step),
        .i_total     (r_total),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_pcm_out   (o_pcm_out),
        .o_is_last   (o_is_last),
        .o_stat      (w_stat)
    );

    // after the final output goes out nothing more follows until the total changes
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_is_last) |=> !o_out_valid)
        else $error("output after the final transaction");

    // a marked output means the count has reached the total
    a_last_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_last) |-> (w_stat.done == r_total))
        else $error("last flag without the total reached");

    // the count of outputs only moves by one, and only while busy
    a_done_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stat.done != $past(w_stat.done)) |->
            (w_stat.busy && (w_stat.done == $past(w_stat.done) + TOTAL_W'(1))))
        else $error("output count moved unexpectedly");

endmodule

`default_nettype wire
